/* src/fan_tachometer_filtered_macros.svh */
// ----------------------------------------------------------------------------
// Fan tachometer assertion macros
// Concurrent check macros used by the tachometer datapath; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef FAN_TACHOMETER_FILTERED_MACROS_SVH
`define FAN_TACHOMETER_FILTERED_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, sampled on i_clk, off during reset
`define FTF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ftf: same-cycle check failed");
// next-cycle implication, sampled on i_clk, off during reset
`define FTF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ftf: next-cycle check failed");
`else
`define FTF_ASSERT_IMP(lbl, ante, cons)
`define FTF_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

/* src/ftf_pkg.sv */
// ----------------------------------------------------------------------------
// Fan tachometer package
// Widths, constants, register indexes, state and control types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ftf_pkg;

    // averaging window depth
    localparam int WIN     = 8;
    localparam int SLOT_W  = (WIN > 1) ? $clog2(WIN) : 1;
    localparam int FILL_W  = $clog2(WIN + 1);

    localparam int RPM_W   = 16;
    localparam int TALLY_W = 16;
    localparam int TIME_W  = 8;
    localparam int PPR_W   = 8;
    localparam int PROD_W  = 22;
    localparam int SUM_W   = RPM_W + SLOT_W;
    localparam int DIV_W   = (PROD_W > SUM_W) ? PROD_W : SUM_W;
    localparam int DVS_W   = (FILL_W > 4) ? FILL_W : 4;
    localparam int DCNT_W  = $clog2(DIV_W);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [5:0]         RPM_PER_PPS = 6'd60;
    localparam logic [DVS_W-1:0]   DEFAULT_PPR = DVS_W'(3);
    localparam logic [PPR_W-1:0]   PPR_LIMIT   = 8'd10;
    localparam logic [TIME_W-1:0]  MIN_GAP_MS  = 8'd2;
    localparam logic [RPM_W-1:0]   RPM_SAT     = 16'hFFFF;
    localparam logic [TALLY_W-1:0] TALLY_SAT   = 16'hFFFF;

    localparam logic REQ_PULSE = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PPR      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RPM_MAX  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RPM_MIN  = 2'd3;

    localparam logic             RST_DEBOUNCE = 1'b1;
    localparam logic [PPR_W-1:0] RST_PPR      = 8'd3;
    localparam logic [RPM_W-1:0] RST_RPM_MAX  = 16'd6000;
    localparam logic [RPM_W-1:0] RST_RPM_MIN  = 16'd100;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RAW_GO,
        S_RAW_WAIT,
        S_CHECK,
        S_SUM,
        S_MEAN_GO,
        S_MEAN_WAIT,
        S_OUT
    } t_ftf_state;

    typedef struct packed {
        logic pulse;
        logic tick;
        logic div_start;
        logic div_mean;
        logic check;
        logic sum_step;
        logic out_load;
    } t_ftf_cmd;

    typedef struct packed {
        logic div_done;
        logic fill_zero;
        logic sum_last;
        logic out_free;
    } t_ftf_sts;

endpackage

`default_nettype wire

/* src/ftf_in_if.sv */
// ----------------------------------------------------------------------------
// Tachometer request channel
// Valid/ready channel carrying pulse events and measurement ticks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ftf_in_if;
    logic                         valid;
    logic                         ready;
    logic                         req_type;
    logic [ftf_pkg::TIME_W-1:0]   time_ms;

    modport source (output valid, output req_type, output time_ms, input ready);
    modport sink   (input valid, input req_type, input time_ms, output ready);
endinterface

`default_nettype wire

/* src/ftf_out_if.sv */
// ----------------------------------------------------------------------------
// Tachometer result channel
// Valid/ready channel carrying one measurement result per tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ftf_out_if;
    logic                        valid;
    logic                        ready;
    logic [ftf_pkg::RPM_W-1:0]   raw_rpm;
    logic                        sample_taken;
    logic [ftf_pkg::RPM_W-1:0]   filtered_rpm;

    modport source (output valid, output raw_rpm, output sample_taken,
                    output filtered_rpm, input ready);
    modport sink   (input valid, input raw_rpm, input sample_taken,
                    input filtered_rpm, output ready);
endinterface

`default_nettype wire

/* src/ftf_div.sv */
// ----------------------------------------------------------------------------
// Tachometer divider
// Restoring divider, one quotient bit per cycle, divisor latched at start.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ftf_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [ftf_pkg::DIV_W-1:0]   i_dividend,
    input  wire logic [ftf_pkg::DVS_W-1:0]   i_divisor,
    output logic                             o_busy,
    output logic                             o_done,
    output logic [ftf_pkg::DIV_W-1:0]        o_quot
);

    logic                          r_busy;
    logic                          r_done;
    logic [ftf_pkg::DCNT_W-1:0]    r_cnt;
    logic [ftf_pkg::DVS_W-1:0]     r_rem;
    logic [ftf_pkg::DVS_W-1:0]     r_dvs;
    logic [ftf_pkg::DIV_W-1:0]     r_quo;

    logic [ftf_pkg::DVS_W:0]       w_shift;
    logic [ftf_pkg::DVS_W:0]       w_diff;
    logic                          w_ge;

    always_comb begin
        w_shift = {r_rem, r_quo[ftf_pkg::DIV_W-1]};
        w_diff  = w_shift - {1'b0, r_dvs};
        w_ge    = (w_shift >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + ftf_pkg::DCNT_W'(1);
                if (r_cnt == ftf_pkg::DCNT_W'(ftf_pkg::DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // shift the dividend out of the top while quotient bits fill the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[ftf_pkg::DIV_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[ftf_pkg::DVS_W-1:0] : w_shift[ftf_pkg::DVS_W-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

`default_nettype wire

/* src/ftf_ctrl.sv */
// ----------------------------------------------------------------------------
// Tachometer controller
// Sequences a tick through divide, check, ring sum, mean divide and output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ftf_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic                i_req_type,
    input  wire ftf_pkg::t_ftf_sts   i_sts,
    output logic                     o_in_ready,
    output ftf_pkg::t_ftf_cmd        o_cmd
);

    ftf_pkg::t_ftf_state r_state;
    ftf_pkg::t_ftf_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ftf_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ftf_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_req_type == ftf_pkg::REQ_TICK) begin
                        o_cmd.tick = 1'b1;
                        n_state    = ftf_pkg::S_RAW_GO;
                    end else begin
                        o_cmd.pulse = 1'b1;
                    end
                end
            end
            ftf_pkg::S_RAW_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = ftf_pkg::S_RAW_WAIT;
            end
            ftf_pkg::S_RAW_WAIT: begin
                if (i_sts.div_done) begin
                    n_state = ftf_pkg::S_CHECK;
                end
            end
            ftf_pkg::S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = ftf_pkg::S_SUM;
            end
            ftf_pkg::S_SUM: begin
                // empty ring: mean is zero, skip the divide
                if (i_sts.fill_zero) begin
                    n_state = ftf_pkg::S_OUT;
                end else begin
                    o_cmd.sum_step = 1'b1;
                    if (i_sts.sum_last) begin
                        n_state = ftf_pkg::S_MEAN_GO;
                    end
                end
            end
            ftf_pkg::S_MEAN_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_mean  = 1'b1;
                n_state         = ftf_pkg::S_MEAN_WAIT;
            end
            ftf_pkg::S_MEAN_WAIT: begin
                if (i_sts.div_done) begin
                    n_state = ftf_pkg::S_OUT;
                end
            end
            ftf_pkg::S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ftf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ftf_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* src/ftf_dp.sv */
// ----------------------------------------------------------------------------
// Tachometer datapath
// Settings, pulse tally, debounce, sample ring, shared divider, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "fan_tachometer_filtered_macros.svh"

module ftf_dp (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire ftf_pkg::t_ftf_cmd                 i_cmd,
    output ftf_pkg::t_ftf_sts                      o_sts,
    input  wire logic [ftf_pkg::TIME_W-1:0]        i_time_ms,
    input  wire logic                              i_cfg_we,
    input  wire logic [ftf_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [ftf_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic                              i_out_ready,
    output logic                                   o_out_valid,
    output logic [ftf_pkg::RPM_W-1:0]              o_raw_rpm,
    output logic                                   o_sample_taken,
    output logic [ftf_pkg::RPM_W-1:0]              o_filtered_rpm
);

    // settings
    logic                           r_deb;
    logic [ftf_pkg::PPR_W-1:0]      r_ppr;
    logic [ftf_pkg::RPM_W-1:0]      r_max;
    logic [ftf_pkg::RPM_W-1:0]      r_min;

    // measurement state
    logic [ftf_pkg::TALLY_W-1:0]    r_tally;
    logic [ftf_pkg::TIME_W-1:0]     r_last;
    logic [ftf_pkg::PROD_W-1:0]     r_prod;
    logic [ftf_pkg::RPM_W-1:0]      r_ring [ftf_pkg::WIN];
    logic [ftf_pkg::SLOT_W-1:0]     r_wslot;
    logic [ftf_pkg::FILL_W-1:0]     r_fill;
    logic [ftf_pkg::SLOT_W-1:0]     r_idx;
    logic [ftf_pkg::SUM_W-1:0]      r_sum;
    logic [ftf_pkg::RPM_W-1:0]      r_raw;
    logic                           r_taken;

    // result register
    logic                           r_ov;
    logic [ftf_pkg::RPM_W-1:0]      r_o_raw;
    logic                           r_o_taken;
    logic [ftf_pkg::RPM_W-1:0]      r_o_mean;

    logic [ftf_pkg::TIME_W-1:0]     w_gap;
    logic                           w_count;
    logic [ftf_pkg::DVS_W-1:0]      w_ppr_eff;
    logic [ftf_pkg::DIV_W-1:0]      w_dividend;
    logic [ftf_pkg::DVS_W-1:0]      w_divisor;
    logic                           w_div_busy;
    logic                           w_div_done;
    logic [ftf_pkg::DIV_W-1:0]      w_quot;
    logic [ftf_pkg::RPM_W-1:0]      w_raw;
    logic                           w_taken;
    logic                           w_out_free;

    always_comb begin
        w_gap   = i_time_ms - r_last;
        w_count = !r_deb || (w_gap >= ftf_pkg::MIN_GAP_MS);
        if (r_ppr == '0 || r_ppr >= ftf_pkg::PPR_LIMIT) begin
            w_ppr_eff = ftf_pkg::DEFAULT_PPR;
        end else begin
            w_ppr_eff = ftf_pkg::DVS_W'(r_ppr[3:0]);
        end
        if (i_cmd.div_mean) begin
            w_dividend = ftf_pkg::DIV_W'(r_sum);
            w_divisor  = ftf_pkg::DVS_W'(r_fill);
        end else begin
            w_dividend = ftf_pkg::DIV_W'(r_prod);
            w_divisor  = w_ppr_eff;
        end
        if (w_quot > ftf_pkg::DIV_W'(ftf_pkg::RPM_SAT)) begin
            w_raw = ftf_pkg::RPM_SAT;
        end else begin
            w_raw = w_quot[ftf_pkg::RPM_W-1:0];
        end
        w_taken    = !((w_raw > r_max) || ((w_raw != '0) && (w_raw < r_min)));
        w_out_free = !r_ov || i_out_ready;
    end

    ftf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deb <= ftf_pkg::RST_DEBOUNCE;
            r_ppr <= ftf_pkg::RST_PPR;
            r_max <= ftf_pkg::RST_RPM_MAX;
            r_min <= ftf_pkg::RST_RPM_MIN;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ftf_pkg::CFG_DEBOUNCE: r_deb <= i_cfg_data[0];
                ftf_pkg::CFG_PPR:      r_ppr <= i_cfg_data[ftf_pkg::PPR_W-1:0];
                ftf_pkg::CFG_RPM_MAX:  r_max <= i_cfg_data[ftf_pkg::RPM_W-1:0];
                ftf_pkg::CFG_RPM_MIN:  r_min <= i_cfg_data[ftf_pkg::RPM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tally <= '0;
            r_last  <= '0;
            r_wslot <= '0;
            r_fill  <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cmd.pulse && w_count) begin
                if (r_tally != ftf_pkg::TALLY_SAT) begin
                    r_tally <= r_tally + ftf_pkg::TALLY_W'(1);
                end
                // only a debounced pulse moves the reference time
                if (r_deb) begin
                    r_last <= i_time_ms;
                end
            end
            if (i_cmd.tick) begin
                r_tally <= '0;
            end
            if (i_cmd.check && w_taken) begin
                if (r_wslot == ftf_pkg::SLOT_W'(ftf_pkg::WIN - 1)) begin
                    r_wslot <= '0;
                end else begin
                    r_wslot <= r_wslot + ftf_pkg::SLOT_W'(1);
                end
                if (r_fill != ftf_pkg::FILL_W'(ftf_pkg::WIN)) begin
                    r_fill <= r_fill + ftf_pkg::FILL_W'(1);
                end
            end
            if (i_cmd.out_load) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tick) begin
            r_prod <= ftf_pkg::PROD_W'(r_tally) * ftf_pkg::PROD_W'(ftf_pkg::RPM_PER_PPS);
        end
        if (i_cmd.check) begin
            r_raw   <= w_raw;
            r_taken <= w_taken;
            r_sum   <= '0;
            r_idx   <= '0;
            if (w_taken) begin
                r_ring[r_wslot] <= w_raw;
            end
        end
        if (i_cmd.sum_step) begin
            r_sum <= r_sum + ftf_pkg::SUM_W'(r_ring[r_idx]);
            r_idx <= r_idx + ftf_pkg::SLOT_W'(1);
        end
        if (i_cmd.out_load) begin
            r_o_raw   <= r_raw;
            r_o_taken <= r_taken;
            r_o_mean  <= (r_fill == '0) ? '0 : w_quot[ftf_pkg::RPM_W-1:0];
        end
    end

    always_comb begin
        o_sts.div_done  = w_div_done;
        o_sts.fill_zero = (r_fill == '0);
        o_sts.sum_last  = (ftf_pkg::FILL_W'(r_idx) == (r_fill - ftf_pkg::FILL_W'(1)));
        o_sts.out_free  = w_out_free;
    end

    assign o_out_valid    = r_ov;
    assign o_raw_rpm      = r_o_raw;
    assign o_sample_taken = r_o_taken;
    assign o_filtered_rpm = r_o_mean;

    `FTF_ASSERT_IMP(a_fill_bound, 1'b1, r_fill <= ftf_pkg::FILL_W'(ftf_pkg::WIN))
    `FTF_ASSERT_IMP(a_slot_tracks_fill, r_fill != ftf_pkg::FILL_W'(ftf_pkg::WIN), r_wslot == r_fill[ftf_pkg::SLOT_W-1:0])
    `FTF_ASSERT_NXT(a_tick_clears_tally, i_cmd.tick, r_tally == '0)
    `FTF_ASSERT_NXT(a_div_launch, i_cmd.div_start, w_div_busy && !w_div_done)

endmodule

`default_nettype wire

/* src/fan_tachometer_filtered.sv */
// ----------------------------------------------------------------------------
// Fan tachometer with moving-average filter
// Counts debounced tach pulses, turns each one-second tick into an RPM sample,
// rejects outliers and reports the mean of the last WIN accepted samples.
// ----------------------------------------------------------------------------
// A pulse beat is absorbed in the cycle it is accepted and returns nothing.
// A tick beat returns one result beat after the raw divide, the outlier
// check, the sum of the F filled ring entries (F counted with the new sample
// in), the mean divide and the output load. On an empty ring the mean divide
// is skipped and a zero mean is loaded. The time goes to two passes through
// the one-bit-per-cycle divider (one for count*60/ppr and one for the mean)
// and to one ring entry summed per cycle. No request beat is taken while a
// tick is in progress; the next one can be taken in the cycle after the
// result is loaded. A finished result waits in the output register and pulses
// are still taken while it waits. The user must write settings through the
// plain write port only while the block is idle; the block does not check it.
`timescale 1ns / 1ps
`default_nettype none

module fan_tachometer_filtered (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    ftf_in_if.sink                                 i_req,
    ftf_out_if.source                              o_res,
    input  wire logic                              i_cfg_we,
    input  wire logic [ftf_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [ftf_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    ftf_pkg::t_ftf_cmd              w_cmd;
    ftf_pkg::t_ftf_sts              w_sts;
    logic                           w_in_ready;
    logic                           w_out_valid;
    logic [ftf_pkg::RPM_W-1:0]      w_raw_rpm;
    logic                           w_sample_taken;
    logic [ftf_pkg::RPM_W-1:0]      w_filtered_rpm;

    ftf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_req_type (i_req.req_type),
        .i_sts      (w_sts),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    ftf_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_time_ms      (i_req.time_ms),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_out_ready    (o_res.ready),
        .o_out_valid    (w_out_valid),
        .o_raw_rpm      (w_raw_rpm),
        .o_sample_taken (w_sample_taken),
        .o_filtered_rpm (w_filtered_rpm)
    );

    assign i_req.ready        = w_in_ready;
    assign o_res.valid        = w_out_valid;
    assign o_res.raw_rpm      = w_raw_rpm;
    assign o_res.sample_taken = w_sample_taken;
    assign o_res.filtered_rpm = w_filtered_rpm;

endmodule

`default_nettype wire
